>>> design/dtsq_pkg.sv
// types and constants shared by the deadline sorted timeout queue
`timescale 1ns / 1ps

package dtsq_pkg;

  localparam logic [1:0] CMD_ARM    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_POLL   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ARG = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [31:0] INFINITE_MS = 32'hFFFF_FFFF;
  localparam logic [20:0] TPM_RESET   = 21'd1000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] task_id;
    logic [31:0] timeout_ms;
    logic [31:0] task_duration_ms;
    logic [63:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        expired_valid;
    logic [15:0] expired_task_id;
    logic        armed;
    logic [63:0] wake_time;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] task_id;
    logic [63:0] deadline;
  } entry_t;

  typedef struct packed {
    logic   arm_en;
    logic   rm_en;
    logic   pop_en;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

>>> design/dtsq_ifs.sv
// request and response channel interfaces of the timeout queue
`timescale 1ns / 1ps

interface dtsq_req_if;
  logic           valid;
  logic           ready;
  dtsq_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dtsq_rsp_if;
  logic           valid;
  logic           ready;
  dtsq_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/dtsq_cell.sv
// one slot of the sorted timeout chain
`timescale 1ns / 1ps

module dtsq_cell (
  input  logic                 clk,
  input  dtsq_pkg::cell_ctrl_t ctrl,
  input  logic                 occ,
  input  logic                 left_ins,
  input  logic                 left_seen,
  input  dtsq_pkg::entry_t     left_entry,
  input  dtsq_pkg::entry_t     right_entry,
  output logic                 ins,
  output logic                 seen,
  output dtsq_pkg::entry_t     entry
);
  import dtsq_pkg::*;

  // insert point: empty slot or strictly later deadline
  assign ins  = !occ || (entry.deadline > ctrl.new_entry.deadline);
  assign seen = left_seen || (occ && (entry.task_id == ctrl.new_entry.task_id));

  always_ff @(posedge clk) begin
    if (ctrl.arm_en && ins) begin
      entry <= left_ins ? left_entry : ctrl.new_entry;
    end else if ((ctrl.rm_en && seen) || ctrl.pop_en) begin
      entry <= right_entry;
    end
  end

endmodule

>>> design/deadline_sorted_timeout_queue.sv
// top level of the deadline sorted timeout queue
//
// Commands arrive as transactions on req (arm, remove, poll) and each one
// gives exactly one transaction on rsp with status, the popped task if any,
// and the armed flag, wake time and entry count after the command.
// ticks_per_ms is written through cfg_we / cfg_wdata; the user must write it
// only while the block is idle, the block itself does not enforce this.
// A request passes, in order, timeout select and the 32x21 multiply, the
// saturating 64-bit add, the chain of slots to insert, remove or pop in
// parallel, and the load of the response register; a new request is taken
// only after the response for the last one is loaded.
// If rsp stalls, the finished response waits in its register and the block
// holds req.ready low until it can load the next response.
// Reset empties the table and sets ticks_per_ms to 1000; slot contents are
// not cleared, only slots below the entry count are ever read.
`timescale 1ns / 1ps

module deadline_sorted_timeout_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata,
  dtsq_req_if.sink    req,
  dtsq_rsp_if.source  rsp
);
  import dtsq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_ADD   = 5'b00100,
    S_CELLS = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [20:0]        ticks_per_ms;
  req_t               item;
  logic [52:0]        delta;
  logic [63:0]        deadline;
  logic [CNT_W-1:0]   count;
  logic [1:0]         status;
  logic               expired_valid;
  logic [15:0]        expired_task_id;

  logic [31:0]        tmo_sel;
  logic [64:0]        sum;
  logic               arm_ok;
  logic               pop_ok;
  logic               rm_go;
  logic [CNT_W+4:0]   count_ext;
  cell_ctrl_t         ctrl;
  logic               cell_ins [DEPTH];
  logic               cell_seen [DEPTH];
  entry_t             cell_entry [DEPTH];

  assign tmo_sel = (item.timeout_ms != 32'd0) ? item.timeout_ms :
                   (item.task_duration_ms != 32'd0) ? item.task_duration_ms : INFINITE_MS;
  assign sum     = {1'b0, item.now} + {12'd0, delta};

  assign arm_ok = (state == S_CELLS) && (item.cmd == CMD_ARM) &&
                  (item.task_id != 16'd0) && (count < CNT_W'(DEPTH));
  assign rm_go  = (state == S_CELLS) && (item.cmd == CMD_REMOVE);
  assign pop_ok = (state == S_CELLS) && (item.cmd == CMD_POLL) && (count != '0) &&
                  (item.now > cell_entry[0].deadline);

  assign ctrl.arm_en            = arm_ok;
  assign ctrl.rm_en             = rm_go;
  assign ctrl.pop_en            = pop_ok;
  assign ctrl.new_entry.task_id  = item.task_id;
  assign ctrl.new_entry.deadline = deadline;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   occ;
    logic   l_ins;
    logic   l_seen;
    entry_t l_entry;
    entry_t r_entry;

    assign occ = (CNT_W'(i) < count);
    if (i == 0) begin : g_head
      assign l_ins   = 1'b0;
      assign l_seen  = 1'b0;
      assign l_entry = ctrl.new_entry;
    end else begin : g_body
      assign l_ins   = cell_ins[i-1];
      assign l_seen  = cell_seen[i-1];
      assign l_entry = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign r_entry = cell_entry[i];
    end else begin : g_next
      assign r_entry = cell_entry[i+1];
    end

    dtsq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ),
      .left_ins    (l_ins),
      .left_seen   (l_seen),
      .left_entry  (l_entry),
      .right_entry (r_entry),
      .ins         (cell_ins[i]),
      .seen        (cell_seen[i]),
      .entry       (cell_entry[i])
    );
  end

  assign req.ready = (state == S_IDLE);
  assign count_ext = {5'd0, count};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req.valid) state_next = S_MUL;
      S_MUL:   state_next = S_ADD;
      S_ADD:   state_next = S_CELLS;
      S_CELLS: state_next = S_OUT;
      S_OUT:   if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ticks_per_ms <= TPM_RESET;
      count        <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        ticks_per_ms <= cfg_wdata;
      end
      if (arm_ok) begin
        count <= count + CNT_W'(1);
      end else if (pop_ok || (rm_go && cell_seen[DEPTH-1])) begin
        count <= count - CNT_W'(1);
      end
      if (state == S_OUT && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item <= req.data;
    end
    if (state == S_MUL) begin
      delta <= 53'(tmo_sel) * 53'(ticks_per_ms);
    end
    if (state == S_ADD) begin
      deadline <= sum[64] ? '1 : sum[63:0];
    end
    if (state == S_CELLS) begin
      if (item.cmd == CMD_ARM && item.task_id == 16'd0) begin
        status <= ST_BAD_ARG;
      end else if (item.cmd == CMD_ARM && count >= CNT_W'(DEPTH)) begin
        status <= ST_FULL;
      end else begin
        status <= ST_OK;
      end
      expired_valid   <= pop_ok;
      expired_task_id <= pop_ok ? cell_entry[0].task_id : 16'd0;
    end
    if (state == S_OUT && (!rsp.valid || rsp.ready)) begin
      rsp.data.status          <= status;
      rsp.data.expired_valid   <= expired_valid;
      rsp.data.expired_task_id <= expired_task_id;
      rsp.data.armed           <= (count != '0);
      rsp.data.wake_time       <= (count != '0) ? cell_entry[0].deadline : 64'd0;
      rsp.data.entry_count     <= count_ext[4:0];
    end
  end

endmodule

>>> design/dtsq_checker.sv
// port level checks of the timeout queue and their bind
`timescale 1ns / 1ps

module dtsq_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input dtsq_pkg::rsp_t rsp_data
);
  import dtsq_pkg::*;

  // stalled response transaction holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  // one request in flight at a time
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_armed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.entry_count != 5'd0 |-> rsp_data.armed)
    else $error("entries pending but timer not armed");

  a_wake_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.armed |-> rsp_data.wake_time == 64'd0)
    else $error("wake time set while disarmed");

  a_expired: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.expired_valid |->
      rsp_data.expired_task_id != 16'd0 && rsp_data.status == ST_OK)
    else $error("bad expired transaction");

endmodule

bind deadline_sorted_timeout_queue dtsq_checker u_dtsq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
